>>> hdl/sbc_pkg.sv
`timescale 1ns / 1ps
// sbc_pkg: constants, command and register codes for the separable blur pass
// no dependencies

package sbc_pkg;

  localparam int MAX_WIDTH      = 256;
  localparam int MAX_HEIGHT     = 256;
  localparam int MAX_TAPS       = 31;
  localparam int COLOR_CHANNELS = 3;

  localparam int CH_W   = 8;
  localparam int COEF_W = 16;
  localparam int DIM_W  = 9;
  localparam int KS_W   = 5;
  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int CRD_W  = (X_W > Y_W) ? X_W : Y_W;
  localparam int POS_W  = CRD_W + 2;
  localparam int ADDR_W = X_W + Y_W;
  localparam int TAP_W  = $clog2(MAX_TAPS);
  localparam int ACC_W  = CH_W + COEF_W + $clog2(MAX_TAPS);
  localparam int PIX_W  = CH_W * COLOR_CHANNELS;
  localparam int FRAC_W = 16;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [1:0] {
    CMD_WR_PIX  = 2'd0,
    CMD_WR_COEF = 2'd1,
    CMD_RD_PIX  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DIR    = 2'd2,
    REG_KSIZE  = 2'd3
  } reg_e;

endpackage

>>> hdl/separable_blur_convolution_pass.sv
`timescale 1ns / 1ps
// separable_blur_convolution_pass: frame store, coefficient store and tap sequencer
// depends on sbc_pkg
//
// A filtered read occupies the block from its transfer until its result is loaded: one tap
// a cycle is fetched through the single read port of the frame memory, with three
// multiply-accumulates per cycle, then the drain state takes the last product and the done
// state loads the output register; an empty kernel goes straight to the done state. The
// result waits there for its transfer; a following write is still taken meanwhile, while a
// following read holds in its done state until the earlier result has left. The frame store
// is not cleared.

module separable_blur_convolution_pass
  import sbc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [X_W-1:0]     pixel_x_i,
  input  logic [Y_W-1:0]     pixel_y_i,
  input  logic [CH_W-1:0]    red_in_i,
  input  logic [CH_W-1:0]    green_in_i,
  input  logic [CH_W-1:0]    blue_in_i,
  input  logic [KS_W-1:0]    coef_index_i,
  input  logic [COEF_W-1:0]  coef_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CH_W-1:0]    red_out_o,
  output logic [CH_W-1:0]    green_out_o,
  output logic [CH_W-1:0]    blue_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [DIM_W-1:0] width_q, height_q;
  logic             dir_q;
  logic [KS_W-1:0]  ksize_q;

  pixel_t           frame_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [COEF_W-1:0] coef_mem [MAX_TAPS];

  logic signed [POS_W-1:0] pos_q;
  logic [CRD_W-1:0]  other_q;
  logic [TAP_W-1:0]  tap_q;
  logic              rd_vld_q;
  pixel_t            rd_data_q;
  logic [COEF_W-1:0] coef_q;
  logic [ACC_W-1:0]  acc_q [COLOR_CHANNELS];

  logic              out_valid_q;
  logic [CH_W-1:0]   res_q [COLOR_CHANNELS];

  cmd_e             cmd;
  reg_e             reg_idx;
  logic             in_xfer, cfg_wr;
  logic [CRD_W-1:0] lim_x, lim_y, lim_pos, lim_oth, ctr_pos, ctr_oth;
  logic [CRD_W-1:0] oth_clamped, pos_clamped, tx, ty;
  logic [KS_W-1:0]  ntaps, radius;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic             last_tap, out_load;

  assign cmd     = cmd_e'(cmd_i);
  assign reg_idx = reg_e'(paddr[3:2]);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  // effective frame limits, zero acts as one and oversize as the maximum
  always_comb begin
    if (width_q == '0) lim_x = '0;
    else if (width_q > DIM_W'(MAX_WIDTH)) lim_x = CRD_W'(MAX_WIDTH - 1);
    else lim_x = CRD_W'(width_q - DIM_W'(1));
    if (height_q == '0) lim_y = '0;
    else if (height_q > DIM_W'(MAX_HEIGHT)) lim_y = CRD_W'(MAX_HEIGHT - 1);
    else lim_y = CRD_W'(height_q - DIM_W'(1));
  end

  always_comb begin
    ntaps  = (ksize_q > KS_W'(MAX_TAPS)) ? KS_W'(MAX_TAPS) : ksize_q;
    radius = ksize_q >> 1;
    lim_pos = dir_q ? lim_y : lim_x;
    lim_oth = dir_q ? lim_x : lim_y;
    ctr_pos = dir_q ? CRD_W'(pixel_y_i) : CRD_W'(pixel_x_i);
    ctr_oth = dir_q ? CRD_W'(pixel_x_i) : CRD_W'(pixel_y_i);
    oth_clamped = (ctr_oth > lim_oth) ? lim_oth : ctr_oth;
    if (pos_q < 0) pos_clamped = '0;
    else if (pos_q > $signed({2'b00, lim_pos})) pos_clamped = lim_pos;
    else pos_clamped = pos_q[CRD_W-1:0];
    tx = dir_q ? other_q : pos_clamped;
    ty = dir_q ? pos_clamped : other_q;
    rd_addr  = {ty[Y_W-1:0], tx[X_W-1:0]};
    wr_addr  = {pixel_y_i, pixel_x_i};
    last_tap = ({{(KS_W-TAP_W){1'b0}}, tap_q} == ntaps - KS_W'(1));
    out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && cmd == CMD_RD_PIX) begin
          state_d = (ntaps == '0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (last_tap) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= DIM_W'(MAX_WIDTH);
      height_q    <= DIM_W'(MAX_HEIGHT);
      dir_q       <= 1'b0;
      ksize_q     <= KS_W'(MAX_TAPS);
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == S_RUN);
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
          REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
          REG_DIR:    dir_q    <= pwdata[0];
          REG_KSIZE:  ksize_q  <= pwdata[KS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_WIDTH:  prdata = PDATA_W'(width_q);
      REG_HEIGHT: prdata = PDATA_W'(height_q);
      REG_DIR:    prdata = PDATA_W'(dir_q);
      REG_KSIZE:  prdata = PDATA_W'(ksize_q);
      default:    prdata = '0;
    endcase
  end

  // tap sequencer and accumulators
  always_ff @(posedge clk_i) begin
    if (in_xfer && cmd == CMD_RD_PIX) begin
      pos_q   <= $signed({2'b00, ctr_pos}) - $signed({{(POS_W-KS_W){1'b0}}, radius});
      other_q <= oth_clamped;
      tap_q   <= '0;
      for (int c = 0; c < COLOR_CHANNELS; c++) acc_q[c] <= '0;
    end else begin
      if (state_q == S_RUN) begin
        pos_q <= pos_q + POS_W'(1);
        tap_q <= tap_q + TAP_W'(1);
      end
      if (rd_vld_q) begin
        for (int c = 0; c < COLOR_CHANNELS; c++) begin
          acc_q[c] <= acc_q[c] + ACC_W'({{COEF_W{1'b0}}, rd_data_q[c*CH_W +: CH_W]} *
                                        {{CH_W{1'b0}}, coef_q});
        end
      end
    end
  end

  // rounding half up and saturation
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int c = 0; c < COLOR_CHANNELS; c++) begin
        logic [ACC_W:0] rnd;
        rnd = {1'b0, acc_q[c]} + (ACC_W+1)'(1 << (FRAC_W - 1));
        if (rnd[ACC_W:FRAC_W] > (ACC_W+1-FRAC_W)'((1 << CH_W) - 1)) res_q[c] <= '1;
        else res_q[c] <= rnd[FRAC_W +: CH_W];
      end
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_xfer && cmd == CMD_WR_PIX) begin
      frame_mem[wr_addr] <= {blue_in_i, green_in_i, red_in_i};
    end
    if (state_q == S_RUN) rd_data_q <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && cmd == CMD_WR_COEF && coef_index_i < KS_W'(MAX_TAPS)) begin
      coef_mem[coef_index_i[TAP_W-1:0]] <= coef_value_i;
    end
    if (state_q == S_RUN) coef_q <= coef_mem[tap_q];
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = res_q[0];
  assign green_out_o = res_q[1];
  assign blue_out_o  = res_q[2];

endmodule
